>>> hw/rtl/psd_pkg.sv
`default_nettype none
package psd_pkg;

    localparam int CW   = 16;          // coordinate width
    localparam int TF   = 16;          // fraction bits of t
    localparam int DW   = 34;          // squared distance width
    localparam int VW   = CW + 1;      // difference of two coordinates
    localparam int PW   = 2 * VW;      // product of two differences
    localparam int NW   = PW + 2;      // signed dot product
    localparam int DENW = PW;          // squared length
    localparam int DEGW = DENW + 17;   // squared length times 1e5
    localparam int QW   = TF + 1;      // quotient bits
    localparam int RW   = DENW + QW + 1;
    localparam int PRW  = QW + VW + 2;
    localparam int ONW  = 35;          // low distance byte times 1e8
    localparam int CFG_AW = 3;

    localparam logic [16:0]    DEG_SCALE = 17'd100000;
    localparam logic [26:0]    ON_SCALE  = 27'd100000000;
    localparam logic [QW-1:0]  T_ONE     = QW'(1) << TF;
    localparam logic [PRW-1:0] T_HALF    = PRW'(1) << (TF - 1);

    localparam logic [1:0] CASE_INTERIOR = 2'd0;
    localparam logic [1:0] CASE_START    = 2'd1;
    localparam logic [1:0] CASE_END      = 2'd2;
    localparam logic [1:0] CASE_DEGEN    = 2'd3;

    localparam logic [CFG_AW-1:0] REG_A_X = 3'd0;
    localparam logic [CFG_AW-1:0] REG_A_Y = 3'd1;
    localparam logic [CFG_AW-1:0] REG_A_Z = 3'd2;
    localparam logic [CFG_AW-1:0] REG_B_X = 3'd3;
    localparam logic [CFG_AW-1:0] REG_B_Y = 3'd4;
    localparam logic [CFG_AW-1:0] REG_B_Z = 3'd5;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
    } point_in_t;

    typedef struct packed {
        logic [TF:0]   param_t;
        coord_t        near_x;
        coord_t        near_y;
        coord_t        near_z;
        logic [DW-1:0] dist_sq;
        logic [1:0]    case_code;
        logic          on_segment;
    } result_t;

    // one pipeline stage word, fields fill in as the word moves on
    typedef struct packed {
        logic [2:0][CW-1:0]  x;
        logic [2:0][VW-1:0]  v;
        logic [2:0][PW-1:0]  pd;
        logic [2:0][PW-1:0]  pq;
        logic [NW-1:0]       num;
        logic [DENW-1:0]     denom;
        logic [DEGW-1:0]     degk;
        logic [1:0]          code;
        logic [RW-1:0]       rem;
        logic [QW-1:0]       quo;
        logic [QW-1:0]       t;
        logic [2:0][PRW-1:0] prod;
        logic [2:0][CW-1:0]  p;
        logic [2:0][PW-1:0]  sq;
        logic [DW-1:0]       dsq;
        logic                dsq_byte;
        logic [ONW-1:0]      onm;
        logic                on;
    } pipe_t;

endpackage
`default_nettype wire

>>> hw/rtl/point_segment_distance_unit.sv
`default_nettype none
// closest point on the segment a..b to a query point, fully pipelined: one
// point word is taken on every clock (busy stays low) and its result word
// appears on result with done high; the 17 stage restoring divider forms t.
// results cannot be held off, so take them in the cycle done is high. write the end
// points through cfg_wr only while no point is in flight
module point_segment_distance_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire psd_pkg::point_in_t        point,
    output logic                           done,
    output psd_pkg::result_t               result,
    input  wire logic                      cfg_wr,
    input  wire logic [psd_pkg::CFG_AW-1:0] cfg_addr,
    input  wire logic [psd_pkg::CW-1:0]    cfg_data
);
    import psd_pkg::*;

    // stage map
    localparam int S_MUL  = 1;           // products d*v and d*d
    localparam int S_SUM  = 2;           // num and denom
    localparam int S_DEG  = 3;           // denom * 1e5
    localparam int S_CLS  = 4;           // case code, divider setup
    localparam int S_DIV  = 5;           // one quotient bit per stage
    localparam int S_T    = S_DIV + QW;  // t select
    localparam int S_PROD = S_T + 1;     // t * d
    localparam int S_NEAR = S_PROD + 1;  // nearest point
    localparam int S_SQ   = S_NEAR + 1;  // squared differences
    localparam int S_DIST = S_SQ + 1;    // squared distance
    localparam int S_ONM  = S_DIST + 1;  // scaled distance
    localparam int S_ON   = S_ONM + 1;   // on segment flag
    localparam int NST    = S_ON + 1;

    coord_t a_reg [3];
    coord_t b_reg [3];
    logic signed [VW-1:0] d [3];

    pipe_t stg_reg  [NST];
    pipe_t stg_next [NST];
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // end point registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i] <= '0;
                b_reg[i] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            unique case (cfg_addr)
                REG_A_X: a_reg[0] <= cfg_data;
                REG_A_Y: a_reg[1] <= cfg_data;
                REG_A_Z: a_reg[2] <= cfg_data;
                REG_B_X: b_reg[0] <= cfg_data;
                REG_B_Y: b_reg[1] <= cfg_data;
                REG_B_Z: b_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // direction vector; the user must keep it static while points are in flight, the block does not enforce it
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            d[i] = VW'(b_reg[i]) - VW'(a_reg[i]);
    end

    always_comb
    begin
        logic signed [NW-1:0]  absn;
        logic [RW-1:0]         sub;
        logic signed [PRW-1:0] sh;
        logic signed [VW-1:0]  pn;
        logic signed [VW-1:0]  e;
        int                    bp;

        absn = '0;
        sub  = '0;
        sh   = '0;
        pn   = '0;
        e    = '0;
        bp   = 0;

        vld_next = {vld_reg[NST-2:0], accept};

        // entry: differences from the start point
        stg_next[0]   = '0;
        stg_next[0].x = {point.point_z, point.point_y, point.point_x};
        stg_next[0].v[0] = VW'(point.point_x) - VW'(a_reg[0]);
        stg_next[0].v[1] = VW'(point.point_y) - VW'(a_reg[1]);
        stg_next[0].v[2] = VW'(point.point_z) - VW'(a_reg[2]);

        for (int k = 1; k < NST; k++)
            stg_next[k] = stg_reg[k-1];

        for (int i = 0; i < 3; i++)
        begin
            stg_next[S_MUL].pd[i] = PW'(d[i] * $signed(stg_reg[S_MUL-1].v[i]));
            stg_next[S_MUL].pq[i] = PW'(d[i] * d[i]);
        end

        stg_next[S_SUM].num = NW'($signed(stg_reg[S_SUM-1].pd[0]))
                            + NW'($signed(stg_reg[S_SUM-1].pd[1]))
                            + NW'($signed(stg_reg[S_SUM-1].pd[2]));
        stg_next[S_SUM].denom = DENW'(stg_reg[S_SUM-1].pq[0] + stg_reg[S_SUM-1].pq[1]
                                      + stg_reg[S_SUM-1].pq[2]);

        stg_next[S_DEG].degk = DEGW'(stg_reg[S_DEG-1].denom) * DEGW'(DEG_SCALE);

        // classify and set up the divider
        absn = $signed(stg_reg[S_CLS-1].num);
        if (absn < 0)
            absn = -absn;
        if (stg_reg[S_CLS-1].degk < DEGW'(absn))
            stg_next[S_CLS].code = CASE_DEGEN;
        else if (stg_reg[S_CLS-1].denom == '0 || $signed(stg_reg[S_CLS-1].num) < 0)
            stg_next[S_CLS].code = CASE_START;
        else if ($signed(stg_reg[S_CLS-1].num) > $signed(NW'(stg_reg[S_CLS-1].denom)))
            stg_next[S_CLS].code = CASE_END;
        else
            stg_next[S_CLS].code = CASE_INTERIOR;
        stg_next[S_CLS].rem = (RW'(stg_reg[S_CLS-1].num[DENW-1:0]) << QW)
                            + RW'(stg_reg[S_CLS-1].denom);
        stg_next[S_CLS].quo = '0;

        // restoring division by 2*denom, msb first
        for (int j = 0; j < QW; j++)
        begin
            bp  = QW - 1 - j;
            sub = RW'(stg_reg[S_DIV+j-1].denom) << (bp + 1);
            if (stg_reg[S_DIV+j-1].rem >= sub)
            begin
                stg_next[S_DIV+j].rem     = stg_reg[S_DIV+j-1].rem - sub;
                stg_next[S_DIV+j].quo[bp] = 1'b1;
            end
        end

        case (stg_reg[S_T-1].code)
            CASE_INTERIOR:
                stg_next[S_T].t = (stg_reg[S_T-1].quo > T_ONE) ? T_ONE
                                                               : stg_reg[S_T-1].quo;
            CASE_END: stg_next[S_T].t = T_ONE;
            default:  stg_next[S_T].t = '0;
        endcase

        for (int i = 0; i < 3; i++)
            stg_next[S_PROD].prod[i] = PRW'($signed({1'b0, stg_reg[S_PROD-1].t}) * d[i])
                                     + T_HALF;

        for (int i = 0; i < 3; i++)
        begin
            sh = $signed(stg_reg[S_NEAR-1].prod[i]) >>> TF;
            pn = VW'(a_reg[i]) + VW'(sh);
            case (stg_reg[S_NEAR-1].code)
                CASE_INTERIOR: stg_next[S_NEAR].p[i] = CW'(pn);
                CASE_END:      stg_next[S_NEAR].p[i] = b_reg[i];
                default:       stg_next[S_NEAR].p[i] = a_reg[i];
            endcase
        end

        for (int i = 0; i < 3; i++)
        begin
            e = VW'($signed(stg_reg[S_SQ-1].x[i])) - VW'($signed(stg_reg[S_SQ-1].p[i]));
            stg_next[S_SQ].sq[i] = PW'(e * e);
        end

        stg_next[S_DIST].dsq = DW'(stg_reg[S_DIST-1].sq[0] + stg_reg[S_DIST-1].sq[1]
                                   + stg_reg[S_DIST-1].sq[2]);

        // denom stays below 2^34; only squared distances under 256 can pass
        stg_next[S_ONM].dsq_byte = (stg_reg[S_ONM-1].dsq[DW-1:8] == '0);
        stg_next[S_ONM].onm      = ONW'(stg_reg[S_ONM-1].dsq[7:0]) * ONW'(ON_SCALE);

        stg_next[S_ON].on = (stg_reg[S_ON-1].code == CASE_INTERIOR
                             || (stg_reg[S_ON-1].code == CASE_START
                                 && stg_reg[S_ON-1].denom == '0))
                          && stg_reg[S_ON-1].dsq_byte
                          && (stg_reg[S_ON-1].onm <= ONW'(stg_reg[S_ON-1].denom));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        stg_reg <= stg_next;
    end

    // result word straight from the last stage register
    assign done              = vld_reg[NST-1];
    assign result.param_t    = stg_reg[NST-1].t;
    assign result.near_x     = stg_reg[NST-1].p[0];
    assign result.near_y     = stg_reg[NST-1].p[1];
    assign result.near_z     = stg_reg[NST-1].p[2];
    assign result.dist_sq    = stg_reg[NST-1].dsq;
    assign result.case_code  = stg_reg[NST-1].code;
    assign result.on_segment = stg_reg[NST-1].on;

    // a result word only for a point taken the pipeline depth earlier
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, NST))
        else $error("result word without matching start");

    a_end_t: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.case_code == CASE_END |-> result.param_t == T_ONE)
        else $error("clamped end word with t not one");

    a_start_t: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.case_code == CASE_START || result.case_code == CASE_DEGEN)
        |-> result.param_t == '0)
        else $error("start or degenerate word with nonzero t");

    a_on_case: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.on_segment
        |-> (result.case_code == CASE_INTERIOR || result.case_code == CASE_START))
        else $error("on segment flag in end or degenerate case");

endmodule
`default_nettype wire
